[design/lsbc_pkg.sv]
// Package for the level-set boundary cleanup block.
// Holds the code type, level-set codes, stream codes and register indexes.
// No dependencies.
package lsbc_pkg;

   localparam int CODE_W = 3;
   localparam int CFG_W = 11;
   localparam int ROW_W = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int TDATA_W = 8;

   typedef logic signed [CODE_W-1:0] code_type;

   localparam code_type CODE_OUT_LIST = 3'sd1;
   localparam code_type CODE_IN_LIST = -3'sd1;
   localparam code_type CODE_OUT_FAR = 3'sd3;
   localparam code_type CODE_IN_FAR = -3'sd3;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam int FRAME_WIDTH_RESET = 256;
   localparam int FRAME_HEIGHT_RESET = 256;
   localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;

endpackage

[design/lsbc_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered read data.
// A read at the address being written returns the old contents.
// No dependencies.
module lsbc_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[design/level_set_boundary_cleanup.sv]
// Top level of the level-set boundary cleanup block.
// Uses lsbc_pkg and two lsbc_ram instances for the upper and middle row stores.
//
// The req channel carries one transaction per raster pixel (tuser = kind 0,
// tdata = signed 3-bit code) or a drain tick (tuser = kind 1). The rsp channel
// returns the cleaned code of each pixel, with tlast on the final pixel of
// the frame. The result for a pixel of row r passes through the write-back
// stage and the output register once the pixel below it in row r + 1 is
// accepted; the last row comes out on drain ticks, one result per tick.
// The block accepts one transaction per cycle unless the output stalls. Each
// is read from both row stores in the accept cycle and written back as it leaves
// the write-back stage, with forwarding when a following pixel reads the entry being written.
// The csr port sets frame_width (index 0) and frame_height (index 1); any
// write restarts the frame. Reset restores 256 x 256 and a fresh frame; the
// row stores need no clearing, as no result depends on an unwritten entry.
// When rsp_tready is low, one result waits in the output register while one
// more transaction is held in the write-back stage; req_tready then drops.
module level_set_boundary_cleanup #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lsbc_pkg::TDATA_W-1:0]      req_tdata,  // [2:0] phi_value, [7:3] zero
   input  logic [0:0]                        req_tuser,  // [0] kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lsbc_pkg::TDATA_W-1:0]      rsp_tdata,  // [2:0] cleaned_value, [7:3] zero
   output logic                              rsp_tlast,  // frame_last
   input  logic                              csr_we,
   input  logic [lsbc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lsbc_pkg::CFG_W-1:0]        csr_wdata
);

   import lsbc_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
   localparam int RESET_WIDTH = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;

   logic [AW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             draining_ff, draining_in;
   logic [AW-1:0]    last_col_ff, last_col_in;
   logic [ROW_W-1:0] last_row_ff, last_row_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_pixel_ff, s1_emit_ff, s1_last_ff;
   logic             s1_has_up_ff, s1_has_left_ff, s1_has_right_ff;
   logic [AW-1:0]    s1_x_ff;
   code_type         s1_code_ff;

   logic             fwd_up_x_ff, fwd_up_l_ff, fwd_mid_x_ff, fwd_mid_r_ff;
   code_type         fwd_up_data_ff, fwd_mid_data_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   code_type         rsp_code_ff;
   logic             rsp_last_ff;

   logic             accept, is_drain, take_pixel, take_drain, take_any, at_last_col;
   logic             s1_go, up_wr_en, mid_wr_en;
   logic [AW-1:0]    rd_left, rd_right;
   logic [CODE_W-1:0] up_rd_a, up_rd_b, mid_rd_a, mid_rd_b;
   code_type         up_x, up_l, mid_x, mid_r, result;
   logic             pos_blocked, neg_blocked;
   logic [CW-1:0]    width_raw, width_eff;
   logic [CFG_W-1:0] height_eff;

   function automatic logic le_zero(input code_type n);
      return n[CODE_W-1] || (n == '0);
   endfunction

   function automatic logic ge_zero(input code_type n);
      return !n[CODE_W-1];
   endfunction

   assign accept = req_tvalid && req_tready;
   assign is_drain = (req_tuser[0] == KIND_DRAIN);
   assign take_pixel = accept && !is_drain && !draining_ff;
   assign take_drain = accept && is_drain && draining_ff;
   assign take_any = take_pixel || take_drain;
   assign at_last_col = (col_ff == last_col_ff);

   assign s1_go = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign up_wr_en = s1_go;
   assign mid_wr_en = s1_go && s1_pixel_ff;

   assign rd_left = col_ff - AW'(1);
   assign rd_right = col_ff + AW'(1);

   lsbc_ram #(
      .WIDTH (CODE_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper_ram (
      .clock     (clock),
      .wr_en     (up_wr_en),
      .wr_addr   (s1_x_ff),
      .wr_data   (mid_x),
      .rd_en     (take_any),
      .rd_addr_a (col_ff),
      .rd_addr_b (rd_left),
      .rd_data_a (up_rd_a),
      .rd_data_b (up_rd_b)
   );

   lsbc_ram #(
      .WIDTH (CODE_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle_ram (
      .clock     (clock),
      .wr_en     (mid_wr_en),
      .wr_addr   (s1_x_ff),
      .wr_data   (s1_code_ff),
      .rd_en     (take_any),
      .rd_addr_a (col_ff),
      .rd_addr_b (rd_right),
      .rd_data_a (mid_rd_a),
      .rd_data_b (mid_rd_b)
   );

   always_comb begin
      up_x = fwd_up_x_ff ? fwd_up_data_ff : code_type'(up_rd_a);
      up_l = fwd_up_l_ff ? fwd_up_data_ff : code_type'(up_rd_b);
      mid_x = fwd_mid_x_ff ? fwd_mid_data_ff : code_type'(mid_rd_a);
      mid_r = fwd_mid_r_ff ? fwd_mid_data_ff : code_type'(mid_rd_b);

      pos_blocked = (s1_has_up_ff && le_zero(up_x)) || (s1_has_left_ff && le_zero(up_l))
         || (s1_has_right_ff && le_zero(mid_r)) || (s1_pixel_ff && le_zero(s1_code_ff));
      neg_blocked = (s1_has_up_ff && ge_zero(up_x)) || (s1_has_left_ff && ge_zero(up_l))
         || (s1_has_right_ff && ge_zero(mid_r)) || (s1_pixel_ff && ge_zero(s1_code_ff));

      if (mid_x == CODE_OUT_LIST) begin
         result = pos_blocked ? mid_x : CODE_OUT_FAR;
      end else if (mid_x == CODE_IN_LIST) begin
         result = neg_blocked ? mid_x : CODE_IN_FAR;
      end else begin
         result = mid_x;
      end
   end

   always_comb begin
      width_raw = CW'(csr_wdata);
      if (width_raw == '0) begin
         width_eff = CW'(1);
      end else if (width_raw > CW'(MAX_WIDTH)) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      if (csr_wdata == '0) begin
         height_eff = CFG_W'(1);
      end else if (csr_wdata > HEIGHT_LIMIT) begin
         height_eff = HEIGHT_LIMIT;
      end else begin
         height_eff = csr_wdata;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      draining_in = draining_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
         draining_in = 1'b0;
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               last_col_in = AW'(width_eff - CW'(1));
            end
            CSR_FRAME_HEIGHT: begin
               last_row_in = ROW_W'(height_eff - CFG_W'(1));
            end
         endcase
      end else if (take_pixel) begin
         if (at_last_col) begin
            col_in = '0;
            if (row_ff == last_row_ff) begin
               draining_in = 1'b1;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + AW'(1);
         end
      end else if (take_drain) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = '0;
            draining_in = 1'b0;
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_comb begin
      if (take_any) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_go && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         draining_ff <= 1'b0;
         last_col_ff <= AW'(RESET_WIDTH - 1);
         last_row_ff <= ROW_W'(FRAME_HEIGHT_RESET - 1);
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         draining_ff <= draining_in;
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_any) begin
         s1_pixel_ff <= take_pixel;
         s1_emit_ff <= take_drain || (row_ff != '0);
         s1_last_ff <= take_drain && at_last_col;
         s1_has_up_ff <= take_pixel ? (row_ff >= ROW_W'(2)) : (last_row_ff != '0);
         s1_has_left_ff <= (col_ff != '0);
         s1_has_right_ff <= !at_last_col;
         s1_x_ff <= col_ff;
         s1_code_ff <= code_type'(req_tdata[CODE_W-1:0]);
         fwd_up_x_ff <= up_wr_en && (s1_x_ff == col_ff);
         fwd_up_l_ff <= up_wr_en && (s1_x_ff == rd_left);
         fwd_mid_x_ff <= mid_wr_en && (s1_x_ff == col_ff);
         fwd_mid_r_ff <= mid_wr_en && (s1_x_ff == rd_right);
         fwd_up_data_ff <= mid_x;
         fwd_mid_data_ff <= s1_code_ff;
      end
      if (s1_go && s1_emit_ff) begin
         rsp_code_ff <= result;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(TDATA_W - CODE_W){1'b0}}, rsp_code_ff};
   assign rsp_tlast = rsp_last_ff;

endmodule

[design/lsbc_checker.sv]
// Port-level checker for the level-set boundary cleanup block, with its bind.
// Sees only the top level's ports; no package dependency.
module lsbc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:3] == 5'b00000))
      else $error("Result padding bits are not zero.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Stalled result withdrawn.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled result changed.");

endmodule

bind level_set_boundary_cleanup lsbc_checker u_lsbc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
